// ===== design/pfs_pkg.sv =====
// Shared constants, types and helpers of the persistent flow sketch update block.
package pfs_pkg;

    // Table geometry
    localparam int ROWS      = 4;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COLUMNS   = 1024;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int KEY_BITS  = 64;
    localparam int KEY_BYTES = KEY_BITS / 8;

    // Field widths
    localparam int CNT_W     = 16;
    localparam int HIT_W     = 12;
    localparam int DRAW_W    = 31;
    localparam int TOTAL_W   = 32;
    localparam int SEED_W    = 64;
    localparam int ROWF_W    = 2;
    localparam int IDX_W     = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam logic [HIT_W-1:0] HIT_MAX     = '1;
    localparam logic [HIT_W-1:0] BURST_RESET = 12'd2000;

    // MurmurHash64A multiplier and the seed mix for the key length
    localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] SEED_MIX = 64'(KEY_BYTES) * MUR_M;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SEED0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_BURST = 3'd4;

    typedef enum logic [2:0] {
        OC_INSERTED    = 3'd0,
        OC_HIT         = 3'd1,
        OC_HIT_CLEARED = 3'd2,
        OC_DECAYED     = 3'd3,
        OC_REPLACED    = 3'd4,
        OC_UNCHANGED   = 3'd5,
        OC_WINDOW      = 3'd6
    } outcome_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_EVAL,
        ST_POST,
        ST_DIV,
        ST_APPLY,
        ST_OUT
    } back_state_t;

    // One queued request
    typedef struct packed {
        logic                win;
        logic [KEY_BITS-1:0] key;
        logic [DRAW_W-1:0]   draw;
    } item_t;

    // Counters of one bucket
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] cnt;
        logic [HIT_W-1:0] hits;
    } word_t;

    // Per-window flags of one bucket
    typedef struct packed {
        logic seen;
        logic decayed;
    } flag_t;

    // ceil(h/5) by reciprocal: exact over the whole 12-bit range
    function automatic logic [HIT_W-1:0] fifth_ceil(input logic [HIT_W-1:0] h);
        logic [25:0] p;
        p = (26'(h) + 26'd4) * 26'd3277;
        return HIT_W'(p >> 14);
    endfunction

endpackage

// ===== design/persistent_flow_sketch_update.sv =====
// Top level of the persistent flow sketch update block.
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+--------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: flow_key, random_draw; tuser: req_type
//  m_*      | out       | m_tvalid/m_tready  | tdata: outcome, row_touched, item_total
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (register write)
//
// An update walks the rows in turn: each row runs the hash through one shared 32x32
// multiplier, then a registered table read and an evaluation step. When no row hits,
// a decision step follows, and unless the candidate is already seen or decayed, a
// bit-serial remainder for the decay and a write step.
// After reset, and for every new-window item, a sweep over all 4096 buckets clears
// the table one bucket a cycle (only the flags on a new window). During the reset
// sweep the queue takes up to two requests and the back end starts them once the
// sweep ends.
// A two-entry queue holds requests while the back end works; the result
// register holds a transfer while m_tready is low.
module persistent_flow_sketch_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [63:0] flow_key, [94:64] random_draw, [95] zero
    input  logic [pfs_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] outcome, [4:3] row_touched, [36:5] item_total, [39:37] zero
    output logic [pfs_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfs_pkg::IDX_W-1:0]         cfg_index,
    input  logic [pfs_pkg::SEED_W-1:0]        cfg_data
);
    import pfs_pkg::*;

    logic [ROWS-1:0][SEED_W-1:0] seeds_reg;
    logic [HIT_W-1:0]            burst_reg;
    item_t                       item;
    logic                        item_valid;
    logic                        item_pop;

    // Register writes are always taken; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeds_reg <= '0;
            burst_reg <= BURST_RESET;
        end
        else if (cfg_valid)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                if (cfg_index == REG_SEED0 + IDX_W'(r))
                begin
                    seeds_reg[r] <= cfg_data;
                end
            end
            if (cfg_index == REG_BURST)
            begin
                burst_reg <= cfg_data[HIT_W-1:0];
            end
        end
    end

    // Accept and queue requests
    pfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    // Hash, walk the rows, update the table and hold the result
    pfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop),
        .seeds       (seeds_reg),
        .burst_limit (burst_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== design/pfs_front.sv =====
// Front part: accepts requests, splits out the key and draw, tags window items and queues them.
module pfs_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pfs_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                      s_tuser,
    output pfs_pkg::item_t            item,
    output logic                      item_valid,
    input  logic                      item_pop
);
    import pfs_pkg::*;

    item_t       q_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    item_t       in_item;

    always_comb
    begin
        in_item.win  = s_tuser;
        in_item.key  = s_tdata[KEY_BITS-1:0];
        in_item.draw = s_tdata[64 +: DRAW_W];
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (item_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            if (push && !item_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (item_pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== design/pfs_hash.sv =====
// Row hash unit: MurmurHash64A of one key over a shared 32x32 multiplier.
module pfs_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pfs_pkg::KEY_BITS-1:0] key,
    input  logic [pfs_pkg::SEED_W-1:0]   seed,
    output logic                         done,
    output logic [pfs_pkg::COL_W-1:0]    col
);
    import pfs_pkg::*;

    // Multiply steps of the hash
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_KMIX = 2'd1;
    localparam logic [1:0] OP_H    = 2'd2;
    localparam logic [1:0] OP_FIN  = 2'd3;

    logic [63:0]      a_reg;
    logic [63:0]      acc_reg;
    logic [63:0]      seed_reg;
    logic [1:0]       op_reg;
    logic [1:0]       ph_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [COL_W-1:0] col_reg;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic [63:0]      sum;
    logic [63:0]      mix;

    // Product mod 2^64 from three partial products: lo*lo, lo*hi, hi*lo
    assign mul_a = (ph_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mul_b = (ph_reg == 2'd1) ? MUR_M[63:32] : MUR_M[31:0];
    assign prod  = 64'(mul_a) * 64'(mul_b);
    assign sum   = acc_reg + {prod[31:0], 32'd0};
    assign mix   = sum ^ (sum >> 47);
    assign done  = done_reg;
    assign col   = col_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            seed_reg <= seed;
            ph_reg   <= 2'd0;
            if (KEY_BYTES >= 8)
            begin
                a_reg  <= 64'(key);
                op_reg <= OP_KEY;
            end
            else
            begin
                a_reg  <= seed ^ SEED_MIX ^ 64'(key);
                op_reg <= OP_H;
            end
        end
        else if (busy_reg)
        begin
            case (ph_reg)
                2'd0:
                begin
                    acc_reg <= prod;
                    ph_reg  <= 2'd1;
                end
                2'd1:
                begin
                    acc_reg <= sum;
                    ph_reg  <= 2'd2;
                end
                default:
                begin
                    ph_reg <= 2'd0;
                    op_reg <= op_reg + 2'd1;
                    case (op_reg)
                        OP_KEY:  a_reg <= mix;
                        OP_KMIX: a_reg <= seed_reg ^ SEED_MIX ^ sum;
                        OP_H:    a_reg <= mix;
                        default: col_reg <= mix[COL_W-1:0];
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && ph_reg == 2'd2 && op_reg == OP_FIN)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== design/pfs_back.sv =====
// Back part: walks the rows, updates the bucket table and registers the result.
module pfs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfs_pkg::item_t               item,
    input  logic                         item_valid,
    output logic                         item_pop,
    input  logic [pfs_pkg::ROWS-1:0][pfs_pkg::SEED_W-1:0] seeds,
    input  logic [pfs_pkg::HIT_W-1:0]    burst_limit,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pfs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pfs_pkg::*;

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = '1;
    localparam logic [4:0]        LAST_BIT = 5'(DRAW_W - 1);

    back_state_t state_reg, state_next;

    // Bucket table
    logic [KEY_BITS-1:0] key_mem  [2**ADDR_W];
    word_t               word_mem [2**ADDR_W];
    flag_t               flag_mem [2**ADDR_W];
    logic [KEY_BITS-1:0] key_rd;
    word_t               word_rd;
    flag_t               flag_rd;

    item_t               item_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   clr_reg;
    logic                win_mode_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                have_reg;
    logic [CNT_W-1:0]    min_reg;
    logic [ADDR_W-1:0]   cand_addr_reg;
    logic [ROW_W-1:0]    cand_row_reg;
    word_t               cand_word_reg;
    flag_t               cand_flag_reg;
    logic [CNT_W:0]      rem_reg;
    logic [DRAW_W-1:0]   draw_reg;
    logic [4:0]          bit_reg;
    outcome_t            res_outc_reg;
    logic [ROWF_W-1:0]   res_row_reg;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Hash unit
    logic                hash_start;
    logic [ROW_W-1:0]    hash_row;
    logic                hash_done;
    logic [COL_W-1:0]    hash_col;

    // Control outputs
    logic                key_we;
    logic                word_we;
    logic                flag_we;
    logic [ADDR_W-1:0]   waddr;
    word_t               word_wd;
    flag_t               flag_wd;
    logic                res_set;
    outcome_t            res_outc;
    logic [ROWF_W-1:0]   res_row;
    logic                out_load;

    // Evaluation of the bucket just read
    logic                is_match;
    logic [HIT_W-1:0]    hits_inc;
    logic [CNT_W:0]      cnt_add;
    logic [CNT_W-1:0]    cnt_sat;
    logic [18:0]         cnt5;
    logic [18:0]         min5;
    logic                take;
    logic [CNT_W-1:0]    jval;
    logic                last_row;
    logic                skip_decay;

    // Divider step and decay outcome
    logic [CNT_W+1:0]    div_t;
    logic [CNT_W+1:0]    div_d;
    logic                decay;
    logic [CNT_W-1:0]    dec_cnt;
    logic [HIT_W-1:0]    dec_hits;

    pfs_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   ((state_reg == ST_IDLE) ? item.key : item_reg.key),
        .seed  (seeds[hash_row]),
        .done  (hash_done),
        .col   (hash_col)
    );

    always_comb
    begin
        is_match = word_rd.valid && (key_rd == item_reg.key);
        hits_inc = (word_rd.hits == HIT_MAX) ? word_rd.hits : word_rd.hits + HIT_W'(1);
        cnt_add  = (CNT_W+1)'(word_rd.cnt) + (flag_rd.decayed ? 17'd2 : 17'd1);
        cnt_sat  = cnt_add[CNT_W] ? CNT_MAX : cnt_add[CNT_W-1:0];
        cnt5     = 19'({word_rd.cnt, 2'b00}) + 19'(word_rd.cnt);
        min5     = 19'({min_reg, 2'b00}) + 19'(min_reg);
        take     = !have_reg || (cnt5 < min5 + 19'(word_rd.hits));
        jval     = (cnt5 > 19'(word_rd.hits))
                   ? word_rd.cnt - CNT_W'(fifth_ceil(word_rd.hits)) : '0;
        last_row = (row_reg == LAST_ROW);
        skip_decay = cand_flag_reg.seen || cand_flag_reg.decayed;

        div_t    = {rem_reg, draw_reg[DRAW_W-1]};
        div_d    = (CNT_W+2)'(min_reg) + 18'd1;
        decay    = (rem_reg == (CNT_W+1)'(min_reg));
        dec_cnt  = cand_word_reg.cnt;
        dec_hits = cand_word_reg.hits;
        if (decay)
        begin
            if (dec_cnt != '0)
            begin
                dec_cnt = dec_cnt - CNT_W'(1);
            end
            if (dec_hits != '0)
            begin
                dec_hits = dec_hits - HIT_W'(1);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = win_mode_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item.win ? ST_CLEAR : ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (!word_rd.valid || is_match)
                begin
                    state_next = ST_OUT;
                end
                else if (last_row)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = ST_HASH;
                end
            end
            ST_POST:  state_next = skip_decay ? ST_OUT : ST_DIV;
            ST_DIV:
            begin
                if (bit_reg == LAST_BIT)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        item_pop   = 1'b0;
        hash_start = 1'b0;
        hash_row   = '0;
        key_we     = 1'b0;
        word_we    = 1'b0;
        flag_we    = 1'b0;
        waddr      = addr_reg;
        word_wd    = word_rd;
        flag_wd    = flag_rd;
        res_set    = 1'b0;
        res_outc   = OC_UNCHANGED;
        res_row    = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                waddr   = clr_reg;
                word_we = !win_mode_reg;
                word_wd = '0;
                flag_we = 1'b1;
                flag_wd = '0;
                res_set = 1'b1;
                res_outc = OC_WINDOW;
            end
            ST_IDLE:
            begin
                item_pop   = item_valid;
                hash_start = item_valid && !item.win;
            end
            ST_EVAL:
            begin
                res_row = ROWF_W'(row_reg);
                if (!word_rd.valid)
                begin
                    key_we        = 1'b1;
                    word_we       = 1'b1;
                    flag_we       = 1'b1;
                    word_wd.valid = 1'b1;
                    word_wd.cnt   = flag_rd.seen ? word_rd.cnt : CNT_W'(1);
                    word_wd.hits  = HIT_W'(1);
                    flag_wd.seen  = 1'b1;
                    res_set       = 1'b1;
                    res_outc      = OC_INSERTED;
                end
                else if (is_match)
                begin
                    word_we      = 1'b1;
                    flag_we      = 1'b1;
                    word_wd.hits = hits_inc;
                    word_wd.cnt  = flag_rd.seen ? word_rd.cnt : cnt_sat;
                    flag_wd.seen = 1'b1;
                    res_set      = 1'b1;
                    res_outc     = OC_HIT;
                    if (hits_inc > burst_limit)
                    begin
                        word_wd      = '0;
                        flag_wd.seen = 1'b0;
                        res_outc     = OC_HIT_CLEARED;
                    end
                end
                else if (!last_row)
                begin
                    hash_start = 1'b1;
                    hash_row   = row_reg + ROW_W'(1);
                end
            end
            ST_POST:
            begin
                res_set  = skip_decay;
                res_outc = OC_UNCHANGED;
            end
            ST_APPLY:
            begin
                waddr   = cand_addr_reg;
                word_we = 1'b1;
                flag_we = 1'b1;
                res_set = 1'b1;
                word_wd.valid   = cand_word_reg.valid;
                word_wd.cnt     = dec_cnt;
                word_wd.hits    = dec_hits;
                flag_wd.seen    = cand_flag_reg.seen;
                flag_wd.decayed = cand_flag_reg.decayed || decay;
                res_outc = decay ? OC_DECAYED : OC_UNCHANGED;
                res_row  = decay ? ROWF_W'(cand_row_reg) : '0;
                if (dec_cnt == '0)
                begin
                    key_we       = 1'b1;
                    word_wd.cnt  = CNT_W'(1);
                    word_wd.hits = HIT_W'(1);
                    flag_wd.seen = 1'b1;
                    res_outc     = OC_REPLACED;
                    res_row      = ROWF_W'(cand_row_reg);
                end
            end
            ST_OUT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    // Table read and write
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[waddr] <= item_reg.key;
        end
        key_rd <= key_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[waddr] <= word_wd;
        end
        word_rd <= word_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[waddr] <= flag_wd;
        end
        flag_rd <= flag_mem[addr_reg];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            item_reg <= item;
            row_reg  <= '0;
            have_reg <= 1'b0;
        end
        if (state_reg == ST_HASH && hash_done)
        begin
            addr_reg <= {row_reg, hash_col};
        end
        if (state_reg == ST_EVAL && word_rd.valid && !is_match)
        begin
            row_reg <= row_reg + ROW_W'(1);
            if (take)
            begin
                have_reg      <= 1'b1;
                min_reg       <= jval;
                cand_addr_reg <= addr_reg;
                cand_row_reg  <= row_reg;
                cand_word_reg <= word_rd;
                cand_flag_reg <= flag_rd;
            end
        end
        if (state_reg == ST_POST)
        begin
            rem_reg  <= '0;
            draw_reg <= item_reg.draw;
            bit_reg  <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg  <= (div_t >= div_d) ? (CNT_W+1)'(div_t - div_d) : (CNT_W+1)'(div_t);
            draw_reg <= draw_reg << 1;
            bit_reg  <= bit_reg + 5'd1;
        end
        if (res_set)
        begin
            res_outc_reg <= res_outc;
            res_row_reg  <= res_row;
        end
        if (out_load)
        begin
            m_tdata_reg <= OUT_DATA_W'({total_reg, res_row_reg, res_outc_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            win_mode_reg <= 1'b0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (item_pop)
            begin
                win_mode_reg <= item.win;
                if (!item.win)
                begin
                    total_reg <= total_reg + TOTAL_W'(1);
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
